// ===== hdl/rect_pkg.sv =====
// Package for the rigid/elastic coupling terms block.
// Holds result kinds and shared widths; no dependencies.
package rect_pkg;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned NREG   = 6;
  localparam int unsigned IDX_W  = 3;

  typedef enum logic [1:0] {
    KIND_RESIDUAL = 2'd0,
    KIND_KQQ      = 2'd1,
    KIND_QU       = 2'd2,
    KIND_QW       = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] arm_x;
    logic signed [DATA_W-1:0] arm_y;
    logic signed [DATA_W-1:0] arm_z;
    logic signed [DATA_W-1:0] mult_x;
    logic signed [DATA_W-1:0] mult_y;
    logic signed [DATA_W-1:0] mult_z;
    logic signed [DATA_W-1:0] elastic_dx;
    logic signed [DATA_W-1:0] elastic_dy;
    logic signed [DATA_W-1:0] elastic_dz;
    logic                     final_point;
  } point_t;

  typedef struct packed {
    kind_t                    result_kind;
    logic [1:0]               row_index;
    logic signed [DATA_W-1:0] value_a;
    logic signed [DATA_W-1:0] value_b;
    logic signed [DATA_W-1:0] value_c;
    logic                     end_of_run;
  } result_t;
endpackage

// ===== hdl/rect_if.sv =====
// Valid/ready channel interfaces for points and results.
// Depends on rect_pkg.
interface rect_point_if import rect_pkg::*; ();
  logic   valid;
  logic   ready;
  point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rect_result_if import rect_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rigid_elastic_coupling_terms.sv =====
// An accepted point runs through 9 rotation products, 9 arm/multiplier products and 15
// accumulator updates before its residual result. One request is taken at a time; a
// non-final point yields the residual alone, a final point also yields the sums, and
// no new point is taken until every result has been taken. One shared 32x32 multiplier
// and one shared saturating accumulator adder do all products and accumulator updates.
// Reset (rst, synchronous) restores the identity rotation, zero rigid displacement
// and clears all sums. Depends on rect_pkg and the interfaces in rect_if.sv.
module rigid_elastic_coupling_terms import rect_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  rect_point_if.sink         pt,
  rect_result_if.source      res
);
  localparam int PW = 2 * DATA_W;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_ROT, S_BP, S_ACC, S_OUT
  } state_t;

  logic [CFG_W-1:0] cfg_reg [NREG];
  state_t           state;
  point_t           pnt;
  logic [3:0]       step;
  logic signed [ACC_WIDTH-1:0] kqq [9];
  logic signed [ACC_WIDTH-1:0] qu [3];
  logic signed [ACC_WIDTH-1:0] qw [3];
  logic signed [PW+1:0]        bsum;
  logic signed [DATA_W-1:0]    bv [3];
  logic signed [PW-1:0]        pm [9];
  logic signed [PW-1:0]        trace;
  logic [2:0]                  out_n;

  // Rotation and rigid displacement as a flat list of 32-bit words.
  logic signed [DATA_W-1:0] rw [12];
  always_comb begin
    for (int k = 0; k < NREG; k++) begin
      rw[2*k]   = cfg_reg[k][DATA_W-1:0];
      rw[2*k+1] = cfg_reg[k][CFG_W-1:DATA_W];
    end
  end

  // The value fits in 32 bits when all bits from the sign down to bit 31 agree.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PW+1:0] v);
    if (!v[PW+1] && |v[PW:DATA_W-1])
      return {1'b0, {(DATA_W-1){1'b1}}};
    if (v[PW+1] && !(&v[PW:DATA_W-1]))
      return {1'b1, {(DATA_W-1){1'b0}}};
    return v[DATA_W-1:0];
  endfunction

  // Shared multiplier operand selection.
  logic [1:0] ri, rj;
  logic signed [DATA_W-1:0] ma, mb;
  logic signed [PW-1:0] prod, prod_sh;
  always_comb begin
    case (step)
      4'd0: {ri, rj} = {2'd0, 2'd0};
      4'd1: {ri, rj} = {2'd0, 2'd1};
      4'd2: {ri, rj} = {2'd0, 2'd2};
      4'd3: {ri, rj} = {2'd1, 2'd0};
      4'd4: {ri, rj} = {2'd1, 2'd1};
      4'd5: {ri, rj} = {2'd1, 2'd2};
      4'd6: {ri, rj} = {2'd2, 2'd0};
      4'd7: {ri, rj} = {2'd2, 2'd1};
      4'd8: {ri, rj} = {2'd2, 2'd2};
      default: {ri, rj} = {2'd0, 2'd0};
    endcase
    ma = '0;
    mb = '0;
    if (state == S_ROT) begin
      ma = rw[4'(ri) * 4'd3 + 4'(rj)];
      case (rj)
        2'd0: mb = pnt.arm_x;
        2'd1: mb = pnt.arm_y;
        default: mb = pnt.arm_z;
      endcase
    end else begin
      ma = bv[ri];
      case (rj)
        2'd0: mb = pnt.mult_x;
        2'd1: mb = pnt.mult_y;
        default: mb = pnt.mult_z;
      endcase
    end
    prod = ma * mb;
    prod_sh = prod >>> FRAC_BITS;
  end

  // Shared saturating accumulator adder.
  logic [3:0] acc_sel;
  logic signed [ACC_WIDTH-1:0] acc_a, acc_sum;
  logic signed [PW+1:0]        acc_d;
  logic signed [PW+2:0]        acc_wide;
  always_comb begin
    acc_sel = step;
    if (acc_sel < 4'd9) acc_a = kqq[acc_sel];
    else if (acc_sel < 4'd12) acc_a = qu[2'(acc_sel - 4'd9)];
    else acc_a = qw[2'(acc_sel - 4'd12)];
    case (acc_sel)
      4'd0: acc_d = -(PW+2)'(pm[0] - trace);
      4'd4: acc_d = -(PW+2)'(pm[4] - trace);
      4'd8: acc_d = -(PW+2)'(pm[8] - trace);
      4'd9: acc_d = -(PW+2)'(pnt.mult_x);
      4'd10: acc_d = -(PW+2)'(pnt.mult_y);
      4'd11: acc_d = -(PW+2)'(pnt.mult_z);
      4'd12: acc_d = (PW+2)'(pm[7]) - (PW+2)'(pm[5]);
      4'd13: acc_d = (PW+2)'(pm[2]) - (PW+2)'(pm[6]);
      4'd14: acc_d = (PW+2)'(pm[3]) - (PW+2)'(pm[1]);
      default: acc_d = -(PW+2)'(pm[acc_sel]);
    endcase
    acc_wide = (PW+3)'(acc_a) + (PW+3)'(acc_d);
    if (acc_wide > (PW+3)'(ACC_MAX)) acc_sum = ACC_MAX;
    else if (acc_wide < (PW+3)'(ACC_MIN)) acc_sum = ACC_MIN;
    else acc_sum = acc_wide[ACC_WIDTH-1:0];
  end

  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_WIDTH-1:0] v);
    return sat32((PW+2)'(v));
  endfunction

  logic signed [PW+1:0] r0, r1, r2;
  always_comb begin
    r0 = (PW+2)'(pnt.elastic_dx) - (PW+2)'(rw[9])  + (PW+2)'(pnt.arm_x) - (PW+2)'(bv[0]);
    r1 = (PW+2)'(pnt.elastic_dy) - (PW+2)'(rw[10]) + (PW+2)'(pnt.arm_y) - (PW+2)'(bv[1]);
    r2 = (PW+2)'(pnt.elastic_dz) - (PW+2)'(rw[11]) + (PW+2)'(pnt.arm_z) - (PW+2)'(bv[2]);
  end

  assign pt.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      out_n <= '0;
      res.valid <= 1'b0;
      cfg_reg[0] <= CFG_W'(65536);
      cfg_reg[1] <= '0;
      cfg_reg[2] <= CFG_W'(65536);
      cfg_reg[3] <= '0;
      cfg_reg[4] <= CFG_W'(65536);
      cfg_reg[5] <= '0;
      for (int k = 0; k < 9; k++) kqq[k] <= '0;
      for (int k = 0; k < 3; k++) begin
        qu[k] <= '0;
        qw[k] <= '0;
      end
    end else begin
      if (cfg_we && cfg_index < IDX_W'(NREG)) cfg_reg[cfg_index] <= cfg_data;
      case (state)
        S_IDLE: begin
          if (pt.valid) begin
            pnt <= pt.data;
            step <= '0;
            bsum <= '0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (rj == 2'd2) begin
            bv[ri] <= sat32(bsum + (PW+2)'(prod_sh));
            bsum <= '0;
          end else begin
            bsum <= bsum + (PW+2)'(prod_sh);
          end
          if (step == 4'd8) begin
            step <= '0;
            state <= S_BP;
          end else step <= step + 4'd1;
        end
        S_BP: begin
          pm[step] <= prod_sh;
          if (step == 4'd8) begin
            step <= '0;
            trace <= pm[0] + pm[4] + prod_sh;
            state <= S_ACC;
          end else step <= step + 4'd1;
        end
        S_ACC: begin
          if (step < 4'd9) kqq[step] <= acc_sum;
          else if (step < 4'd12) qu[2'(step - 4'd9)] <= acc_sum;
          else qw[2'(step - 4'd12)] <= acc_sum;
          if (step == 4'd14) begin
            state <= S_OUT;
            out_n <= '0;
            res.valid <= 1'b1;
            res.data.result_kind <= KIND_RESIDUAL;
            res.data.row_index <= '0;
            res.data.value_a <= sat32(r0);
            res.data.value_b <= sat32(r1);
            res.data.value_c <= sat32(r2);
            res.data.end_of_run <= !pnt.final_point;
          end else step <= step + 4'd1;
        end
        S_OUT: begin
          if (res.ready) begin
            if (res.data.end_of_run) begin
              res.valid <= 1'b0;
              state <= S_IDLE;
              if (pnt.final_point) begin
                for (int k = 0; k < 9; k++) kqq[k] <= '0;
                for (int k = 0; k < 3; k++) begin
                  qu[k] <= '0;
                  qw[k] <= '0;
                end
              end
            end else begin
              out_n <= out_n + 3'd1;
              res.data.end_of_run <= (out_n == 3'd4);
              if (out_n < 3'd3) begin
                res.data.result_kind <= KIND_KQQ;
                res.data.row_index <= out_n[1:0];
                res.data.value_a <= sat_acc(kqq[4'(out_n) * 4'd3]);
                res.data.value_b <= sat_acc(kqq[4'(out_n) * 4'd3 + 4'd1]);
                res.data.value_c <= sat_acc(kqq[4'(out_n) * 4'd3 + 4'd2]);
              end else if (out_n == 3'd3) begin
                res.data.result_kind <= KIND_QU;
                res.data.row_index <= '0;
                res.data.value_a <= sat_acc(qu[0]);
                res.data.value_b <= sat_acc(qu[1]);
                res.data.value_c <= sat_acc(qu[2]);
              end else begin
                res.data.result_kind <= KIND_QW;
                res.data.row_index <= '0;
                res.data.value_a <= sat_acc(qw[0]);
                res.data.value_b <= sat_acc(qw[1]);
                res.data.value_c <= sat_acc(qw[2]);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !pt.ready)
    else $error("point accepted while busy");
  ap_valid_only_out: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == S_OUT))
    else $error("result valid outside output phase");
  ap_row_kqq: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.result_kind != KIND_KQQ) |-> (res.data.row_index == 2'd0))
    else $error("row index set on non-row result");
endmodule
